>>> sv/kmp_pkg.sv
// Shared types and constants for the streaming KMP substring matcher.
// No dependencies; every other file imports this package.
package kmp_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int LEN_W       = 5;
  localparam int MATCH_W     = 32;
  localparam int PAT_BYTES   = 16;
  localparam int PAT_IDX_W   = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern_t;

  typedef enum logic {
    BLD_IDLE,
    BLD_RUN
  } bld_state_t;

  typedef enum logic {
    BK_WAIT,
    BK_FALL
  } bk_state_t;

  typedef struct packed {
    logic busy;
    logic cfg_write;
  } tbl_status_t;

endpackage

>>> sv/kmp_fifo.sv
// Short queue between the front and back parts of the KMP matcher.
// Depends on kmp_pkg for the queue depth.
module kmp_fifo
  import kmp_pkg::*;
#(
  parameter int WIDTH = 41
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/kmp_table.sv
// Configuration registers and failure-table builder of the KMP matcher.
// Depends on kmp_pkg; after each write one entry settles per cycle that does not fall back.
module kmp_table
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  len_t                  rd_addr,
  output len_t                  rd_data,
  output len_t                  eff_len,
  output len_t                  last_fail,
  output pattern_t              pattern,
  output tbl_status_t           status
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [CFG_DATA_W-1:0] pat_low_r;
  logic [CFG_DATA_W-1:0] pat_high_r;
  len_t                  pat_len_r;
  len_t                  ft_r [MAX_PATTERN];
  len_t                  i_r, i_nxt;
  len_t                  k_r, k_nxt;
  len_t                  last_fail_r, last_fail_nxt;
  bld_state_t            state_r, state_nxt;

  logic                  wr;
  logic                  building;
  logic                  step;
  logic                  fall;
  logic                  ft_we;
  len_t                  addr;
  logic [IDX_W-1:0]      rd_idx;
  len_t                  ft_q;
  logic [BYTE_W-1:0]     pi;
  logic [BYTE_W-1:0]     pk;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid && (cfg_index == REG_PATTERN_LOW || cfg_index == REG_PATTERN_HIGH ||
                            cfg_index == REG_PATTERN_LENGTH);

  always_comb begin
    if (pat_len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (pat_len_r > LEN_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pat_len_r;
    end
  end

  assign pattern   = {pat_high_r, pat_low_r};
  assign last_fail = last_fail_r;
  assign building  = (state_r == BLD_RUN);

  assign addr    = (building ? k_r : rd_addr) - LEN_W'(1);
  assign rd_idx  = addr[IDX_W-1:0];
  assign ft_q    = ft_r[rd_idx];
  assign rd_data = ft_q;

  assign status.busy      = building;
  assign status.cfg_write = wr;

  always_comb begin
    if (wr) begin
      state_nxt = BLD_RUN;
    end else begin
      unique case (state_r)
        BLD_IDLE: state_nxt = BLD_IDLE;
        BLD_RUN:  state_nxt = (i_r >= eff_len) ? BLD_IDLE : BLD_RUN;
        default:  state_nxt = BLD_IDLE;
      endcase
    end
  end

  always_comb begin
    pi            = pattern[i_r[PAT_IDX_W-1:0]];
    pk            = pattern[k_r[PAT_IDX_W-1:0]];
    step          = building && (i_r < eff_len);
    fall          = (k_r != '0) && (pi != pk);
    ft_we         = 1'b0;
    i_nxt         = i_r;
    k_nxt         = k_r;
    last_fail_nxt = last_fail_r;
    if (wr) begin
      i_nxt         = LEN_W'(1);
      k_nxt         = '0;
      last_fail_nxt = '0;
    end else if (step) begin
      if (fall) begin
        k_nxt = ft_q;
      end else begin
        k_nxt = k_r + ((pi == pk) ? LEN_W'(1) : LEN_W'(0));
        ft_we = 1'b1;
        i_nxt = i_r + LEN_W'(1);
        if (i_r == eff_len - LEN_W'(1)) begin
          last_fail_nxt = k_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r   <= '0;
      pat_high_r  <= '0;
      pat_len_r   <= LEN_W'(1);
      state_r     <= BLD_IDLE;
      i_r         <= LEN_W'(1);
      k_r         <= '0;
      last_fail_r <= '0;
      for (int e = 0; e < MAX_PATTERN; e++) begin
        ft_r[e] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      last_fail_r <= last_fail_nxt;
      if (wr) begin
        if (cfg_index == REG_PATTERN_LOW) begin
          pat_low_r <= cfg_data;
        end
        if (cfg_index == REG_PATTERN_HIGH) begin
          pat_high_r <= cfg_data;
        end
        if (cfg_index == REG_PATTERN_LENGTH) begin
          pat_len_r <= cfg_data[LEN_W-1:0];
        end
        for (int e = 0; e < MAX_PATTERN; e++) begin
          ft_r[e] <= '0;
        end
      end else if (ft_we) begin
        ft_r[i_r[IDX_W-1:0]] <= k_nxt;
      end
    end
  end

endmodule

>>> sv/kmp_front.sv
// Front part of the KMP matcher: accept text beats, tag each with its position.
// Depends on kmp_pkg; feeds kmp_fifo.
module kmp_front
  import kmp_pkg::*;
#(
  parameter int POSITION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [BYTE_W-1:0]        in_text_byte,
  input  logic                     in_first,
  input  tbl_status_t              status,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [POSITION_BITS-1:0] q_pos,
  output logic                     q_first,
  output logic [BYTE_W-1:0]        q_byte
);

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;

  assign in_ready = !status.busy && !status.cfg_write && !q_full;
  assign q_push   = in_valid && in_ready;
  assign q_pos    = in_first ? '0 : pos_r;
  assign q_first  = in_first;
  assign q_byte   = in_text_byte;
  assign pos_nxt  = q_push ? q_pos + POSITION_BITS'(1) : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

>>> sv/kmp_back.sv
// Back part of the KMP matcher: advance the match count, fall back one table
// step per cycle, and hold found start positions in the output register.
// Depends on kmp_pkg; reads kmp_table and drains kmp_fifo.
module kmp_back
  import kmp_pkg::*;
#(
  parameter int POSITION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     hd_valid,
  input  logic [BYTE_W-1:0]        hd_byte,
  input  logic                     hd_first,
  input  logic [POSITION_BITS-1:0] hd_pos,
  output logic                     hd_pop,
  input  len_t                     eff_len,
  input  len_t                     last_fail,
  input  pattern_t                 pattern,
  output len_t                     tbl_rd_addr,
  input  len_t                     tbl_rd_data,
  input  tbl_status_t              status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MATCH_W-1:0]       out_match_start
);

  bk_state_t                state_r, state_nxt;
  len_t                     j_r, j_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [MATCH_W-1:0]       out_start_r;

  len_t                     jw;
  len_t                     jn;
  logic                     hit;
  logic                     fall;
  logic                     full_match;
  logic                     slot_free;
  logic                     load;
  logic [POSITION_BITS-1:0] start;

  assign jw          = (state_r == BK_WAIT && hd_first) ? '0 : j_r;
  assign hit         = (hd_byte == pattern[jw[PAT_IDX_W-1:0]]);
  assign fall        = hd_valid && (jw != '0) && !hit;
  assign jn          = jw + (hit ? LEN_W'(1) : LEN_W'(0));
  assign full_match  = (jn == eff_len);
  assign slot_free   = !out_valid_r || out_ready;
  assign tbl_rd_addr = jw;
  assign start       = hd_pos + POSITION_BITS'(1) - POSITION_BITS'(eff_len);

  always_comb begin
    state_nxt = state_r;
    if (status.cfg_write) begin
      state_nxt = BK_WAIT;
    end else if (fall) begin
      state_nxt = BK_FALL;
    end else if (hd_pop) begin
      state_nxt = BK_WAIT;
    end
  end

  always_comb begin
    hd_pop = 1'b0;
    load   = 1'b0;
    j_nxt  = j_r;
    if (status.cfg_write) begin
      j_nxt = '0;
    end else if (hd_valid) begin
      priority if (fall) begin
        j_nxt = tbl_rd_data;
      end else if (full_match) begin
        if (slot_free) begin
          load   = 1'b1;
          hd_pop = 1'b1;
          j_nxt  = last_fail;
        end else begin
          j_nxt  = jw;
        end
      end else begin
        hd_pop = 1'b1;
        j_nxt  = jn;
      end
    end
  end

  assign out_valid_nxt   = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid       = out_valid_r;
  assign out_match_start = out_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_WAIT;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_start_r <= MATCH_W'(start);
    end
  end

endmodule

>>> sv/kmp_substring_matcher.sv
// Top level of the streaming KMP substring matcher: front, queue, back, table.
// Depends on kmp_pkg, kmp_front, kmp_fifo, kmp_back and kmp_table.
//
//   channel  handshake              payload                         direction
//   in       in_valid / in_ready    in_text_byte[7:0], in_first     to block
//   out      out_valid / out_ready  out_match_start[31:0]           from block
//   cfg      cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[63:0]  to block
//
// In the back part a text beat falls back through the failure table one step per
// cycle until its byte matches or no step is left, and is then taken.
// Each pattern low, high or length write rebuilds the failure table, during
// which in_ready is low. Reset is synchronous; the table resets to zero.
// A full output register stalls the back part only on a match; the queue
// lets the front keep taking beats meanwhile, until the queue is full.
module kmp_substring_matcher
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_text_byte,
  input  logic                  in_first,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MATCH_W-1:0]    out_match_start,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int Q_W = POSITION_BITS + 1 + BYTE_W;

  tbl_status_t              status;
  len_t                     eff_len;
  len_t                     last_fail;
  len_t                     tbl_rd_addr;
  len_t                     tbl_rd_data;
  pattern_t                 pattern;
  logic                     q_full;
  logic                     q_push;
  logic [POSITION_BITS-1:0] q_pos;
  logic                     q_first;
  logic [BYTE_W-1:0]        q_byte;
  logic                     hd_valid;
  logic                     hd_pop;
  logic [Q_W-1:0]           hd_data;

  kmp_table #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rd_addr  (tbl_rd_addr),
    .rd_data  (tbl_rd_data),
    .eff_len  (eff_len),
    .last_fail(last_fail),
    .pattern  (pattern),
    .status   (status)
  );

  kmp_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_text_byte(in_text_byte),
    .in_first    (in_first),
    .status      (status),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_pos       (q_pos),
    .q_first     (q_first),
    .q_byte      (q_byte)
  );

  kmp_fifo #(
    .WIDTH(Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({q_pos, q_first, q_byte}),
    .full      (q_full),
    .pop       (hd_pop),
    .head_valid(hd_valid),
    .head_data (hd_data)
  );

  kmp_back #(
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .hd_valid       (hd_valid),
    .hd_byte        (hd_data[BYTE_W-1:0]),
    .hd_first       (hd_data[BYTE_W]),
    .hd_pos         (hd_data[Q_W-1:BYTE_W+1]),
    .hd_pop         (hd_pop),
    .eff_len        (eff_len),
    .last_fail      (last_fail),
    .pattern        (pattern),
    .tbl_rd_addr    (tbl_rd_addr),
    .tbl_rd_data    (tbl_rd_data),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_match_start(out_match_start)
  );

endmodule

>>> verif/kmp_match_checker.sv
// Scoreboard for the KMP substring matcher: watches the cfg, in and out channels,
// predicts match start positions and compares them beat by beat.
// Depends on kmp_pkg.
module kmp_match_checker
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_text_byte,
  input  logic                  in_first,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [MATCH_W-1:0]    out_match_start,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_starts
);

  logic [CFG_DATA_W-1:0]    pat_lo;
  logic [CFG_DATA_W-1:0]    pat_hi;
  len_t                     len_reg;
  len_t                     matched;
  logic [POSITION_BITS-1:0] text_pos;
  len_t                     fail_tbl [PAT_BYTES];
  logic [MATCH_W-1:0]       expected_starts [$];

  function automatic logic [BYTE_W-1:0] pat_byte(int k);
    logic [2*CFG_DATA_W-1:0] bits;
    bits = {pat_hi, pat_lo};
    return bits[BYTE_W*(k & (PAT_BYTES-1)) +: BYTE_W];
  endfunction

  function automatic int active_len();
    int n;
    n = int'(len_reg);
    if (n == 0) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    if (n > PAT_BYTES) n = PAT_BYTES;
    return n;
  endfunction

  function automatic void rebuild_fail_tbl();
    int n;
    int k;
    n = active_len();
    k = 0;
    for (int i = 0; i < PAT_BYTES; i++) fail_tbl[i] = '0;
    for (int i = 1; i < n; i++) begin
      while (k > 0 && pat_byte(i) != pat_byte(k)) k = int'(fail_tbl[k-1]);
      if (pat_byte(i) == pat_byte(k)) k++;
      fail_tbl[i] = len_t'(k);
    end
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    logic known;
    known = 1'b1;
    case (idx)
      REG_PATTERN_LOW:    pat_lo = val;
      REG_PATTERN_HIGH:   pat_hi = val;
      REG_PATTERN_LENGTH: len_reg = val[LEN_W-1:0];
      default:            known = 1'b0;
    endcase
    if (known) begin
      rebuild_fail_tbl();
      matched = '0;
    end
  endfunction

  function automatic void scan_byte(logic [BYTE_W-1:0] b, logic restart);
    int n;
    int j;
    logic [POSITION_BITS-1:0] start;
    n = active_len();
    if (restart) begin
      text_pos = '0;
      matched = '0;
    end
    j = int'(matched);
    if (j >= n) j = 0;
    while (j > 0 && b != pat_byte(j)) j = int'(fail_tbl[j-1]);
    if (b == pat_byte(j)) j++;
    if (j == n) begin
      start = text_pos - POSITION_BITS'(n) + 1'b1;
      expected_starts.insert(expected_starts.size(), MATCH_W'(start));
      j = int'(fail_tbl[n-1]);
    end
    matched = len_t'(j);
    text_pos = text_pos + 1'b1;
  endfunction

  always @(posedge clk) begin
    logic [MATCH_W-1:0] want_start;
    if (!rst_n) begin
      pat_lo = '0;
      pat_hi = '0;
      len_reg = len_t'(1);
      matched = '0;
      text_pos = '0;
      rebuild_fail_tbl();
      expected_starts.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_starts.size() == 0) begin
          fail_count++;
          $display("%0t: match_start expected none, actual %h", $time, out_match_start);
        end else begin
          want_start = expected_starts.pop_front();
          if (want_start != out_match_start) begin
            fail_count++;
            $display("%0t: match_start expected %h, actual %h", $time, want_start,
                     out_match_start);
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) scan_byte(in_text_byte, in_first);
    end
    pending_starts = expected_starts.size();
  end

endmodule

>>> verif/tb_kmp_substring_matcher.sv
// Top of the KMP substring matcher testbench: clock, reset, stimulus and verdict.
// Depends on kmp_pkg, kmp_substring_matcher and kmp_match_checker.
module tb_kmp_substring_matcher;
  import kmp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 64;
  localparam int TEXT_TARGET  = 1900;
  localparam logic [BYTE_W-1:0] CHAR_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_B = 8'h62;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_text_byte = '0;
  logic                  in_first = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [MATCH_W-1:0]    out_match_start;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending_starts;

  logic                  no_idle = 1'b0;
  logic                  full_range = 1'b0;
  logic [BYTE_W-1:0]     sym_base = '0;
  int                    sym_span = 1;
  logic [CFG_DATA_W-1:0] cur_lo = '0;
  logic [CFG_DATA_W-1:0] cur_hi = '0;
  len_t                  cur_len = len_t'(1);

  kmp_substring_matcher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_first        (in_first),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_start (out_match_start),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  kmp_match_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_first        (in_first),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_start (out_match_start),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_starts  (pending_starts)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 30);
  end

  function automatic logic [BYTE_W-1:0] pick_sym();
    if (full_range) return BYTE_W'($urandom_range(255));
    return BYTE_W'(sym_base + BYTE_W'($urandom_range(sym_span - 1)));
  endfunction

  function automatic int cur_active_len();
    if (cur_len == 0) return 1;
    if (cur_len > PAT_BYTES) return PAT_BYTES;
    return int'(cur_len);
  endfunction

  task automatic send_text(input logic [BYTE_W-1:0] b, input logic restart);
    while (!no_idle && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_first     <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, wait for every pending match, then let the back part drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_starts != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:    cur_lo = val;
      REG_PATTERN_HIGH:   cur_hi = val;
      REG_PATTERN_LENGTH: cur_len = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  initial begin
    int sent;
    int ph;
    int n_items;
    int cnt;
    int el;
    int cut;
    int r;
    int order;
    logic [2*CFG_DATA_W-1:0] pat_now;
    logic [CFG_DATA_W-1:0]   lo_v;
    logic [CFG_DATA_W-1:0]   hi_v;
    len_t                    len_v;

    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset pattern: single zero byte
    send_text(8'h00, 1'b1);
    send_text(8'hFF, 1'b0);

    // overlapping occurrences, then a restart mid-text
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_6261_6261);
    write_reg(REG_PATTERN_HIGH, '1);
    write_reg(REG_PATTERN_LENGTH, 64'd4);
    send_text(CHAR_A, 1'b1);
    send_text(CHAR_B, 1'b0);
    send_text(CHAR_A, 1'b0);
    send_text(CHAR_B, 1'b0);
    send_text(CHAR_A, 1'b0);
    send_text(CHAR_B, 1'b0);
    send_text(CHAR_A, 1'b1);
    send_text(CHAR_B, 1'b0);

    // zero length acts as one; an unknown index changes nothing
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    write_reg(REG_UNUSED, 64'd4);
    send_text(CHAR_A, 1'b0);
    send_text(CHAR_A, 1'b0);

    // oversize length clamps to the full sixteen bytes
    write_reg(REG_PATTERN_LOW, '0);
    write_reg(REG_PATTERN_HIGH, '0);
    write_reg(REG_PATTERN_LENGTH, 64'd31);
    for (int k = 0; k < PAT_BYTES; k++) send_text(8'h00, k == 0);

    sent = 0;
    ph = 0;
    while (sent < TEXT_TARGET) begin
      no_idle    = (ph >= 6 && ph < 12);
      full_range = ($urandom_range(5) == 0);
      sym_base   = BYTE_W'($urandom_range(255));
      sym_span   = $urandom_range(3, 1);
      for (int k = 0; k < 8; k++) begin
        lo_v[BYTE_W*k +: BYTE_W] = pick_sym();
        hi_v[BYTE_W*k +: BYTE_W] = pick_sym();
      end
      r = $urandom_range(19);
      if (r < 12) len_v = len_t'($urandom_range(6, 1));
      else if (r < 16) len_v = len_t'($urandom_range(16, 7));
      else if (r == 16) len_v = '0;
      else len_v = len_t'($urandom_range(31, 17));
      order = $urandom_range(2);
      for (int w = 0; w < 3; w++) begin
        case ((w + order) % 3)
          0:       write_reg(REG_PATTERN_LOW, lo_v);
          1:       write_reg(REG_PATTERN_HIGH, hi_v);
          default: write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len_v));
        endcase
      end
      if ($urandom_range(7) == 0) write_reg(REG_UNUSED, {$urandom(), $urandom()});

      pat_now = {cur_hi, cur_lo};
      el = cur_active_len();
      n_items = $urandom_range(90, 20);
      cnt = 0;
      while (cnt < n_items) begin
        r = $urandom_range(9);
        if (r < 5) cut = el;
        else if (r < 7) cut = $urandom_range(el);
        else cut = 0;
        if (cut > 0) begin
          for (int k = 0; k < cut; k++) begin
            send_text(pat_now[BYTE_W*k +: BYTE_W], $urandom_range(49) == 0);
            cnt++;
          end
        end else begin
          send_text((r == 7) ? BYTE_W'($urandom_range(255)) : pick_sym(),
                    $urandom_range(49) == 0);
          cnt++;
        end
      end
      sent += cnt;
      ph++;
    end

    no_idle = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
sv/kmp_pkg.sv
sv/kmp_fifo.sv
sv/kmp_table.sv
sv/kmp_front.sv
sv/kmp_back.sv
sv/kmp_substring_matcher.sv
verif/kmp_match_checker.sv
verif/tb_kmp_substring_matcher.sv
